// ----- rtl/stfe_pkg.sv -----
// Shared types and constants for the spline table function evaluator.
`default_nettype none
package stfe_pkg;

  localparam int ACC_W      = 48;
  localparam int DIF_W      = 32;
  localparam int DIST_W     = 32;
  localparam int CFG_W      = 32;
  localparam int CFG_IDX_W  = 1;
  localparam int HORNER_LAT = 5;

  localparam logic OP_EVAL  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  localparam logic [1:0] SEL_A = 2'd0;
  localparam logic [1:0] SEL_B = 2'd1;
  localparam logic [1:0] SEL_C = 2'd2;
  localparam logic [1:0] SEL_D = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_CLAMP = 2'd1;
  localparam logic [1:0] ST_KIND  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_STEP_WIDTH   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERSE_STEP = 1'd1;

  localparam logic [ACC_W-1:0] ACC_MAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [ACC_W-1:0] ACC_MIN = 48'h8000_0000_0000;

  typedef struct packed {
    logic                    op;
    logic [2:0]              kind;
    logic [DIST_W-1:0]       distance;
    logic [9:0]              entry;
    logic [1:0]              coef_select;
    logic signed [ACC_W-1:0] coef_value;
  } stfe_in_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] value;
    logic [1:0]              status;
  } stfe_out_t;

endpackage
`default_nettype wire

// ----- rtl/stfe_horner.sv -----
// One Horner step: acc * dif rounded and saturated, plus the next coefficient.
`default_nettype none
module stfe_horner
  import stfe_pkg::*;
#(
  parameter int SB_W = 2
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_vld,
  input  logic signed [ACC_W-1:0] in_acc,
  input  logic signed [DIF_W-1:0] in_dif,
  input  logic signed [ACC_W-1:0] in_coef,
  input  logic [SB_W-1:0]         in_sb,
  output logic                    out_vld,
  output logic signed [ACC_W-1:0] out_acc,
  output logic signed [DIF_W-1:0] out_dif,
  output logic [SB_W-1:0]         out_sb
);

  localparam int LO_W  = 64;
  localparam int HI_W  = ACC_W;
  localparam int MAG_W = HI_W + 9;

  logic [HORNER_LAT-1:0]   vld_r;
  logic signed [DIF_W-1:0] dif_r [HORNER_LAT];
  logic [SB_W-1:0]         sb_r  [HORNER_LAT];
  logic signed [ACC_W-1:0] coef_r [3];

  // stage A: magnitudes
  logic [ACC_W-1:0] a_mc_r, a_mc_nxt;
  logic [DIF_W-1:0] a_md_r, a_md_nxt;
  logic             a_neg_r;
  // stage B: low partial product
  logic [LO_W-1:0]  b_lo_r, b_lo_nxt;
  logic [15:0]      b_mc_hi_r;
  logic [DIF_W-1:0] b_md_r;
  logic             b_neg_r;
  // stage C: high partial product and rounding
  logic [HI_W-1:0]  c_hi;
  logic [LO_W:0]    c_lo_rnd;
  logic [MAG_W-1:0] c_mag_r, c_mag_nxt;
  logic             c_neg_r;
  // stage D: signed add
  logic [ACC_W-1:0]      d_magc;
  logic signed [ACC_W:0] d_sum_r, d_sum_nxt;
  // stage E: saturate
  logic signed [ACC_W-1:0] e_acc_r, e_acc_nxt;

  always_comb begin
    a_mc_nxt = in_acc[ACC_W-1] ? (~in_acc + ACC_W'(1)) : in_acc;
    a_md_nxt = in_dif[DIF_W-1] ? (~in_dif + DIF_W'(1)) : in_dif;
  end

  assign b_lo_nxt = LO_W'(a_mc_r[31:0]) * LO_W'(a_md_r);

  always_comb begin
    c_hi      = HI_W'(b_mc_hi_r) * HI_W'(b_md_r);
    c_lo_rnd  = {1'b0, b_lo_r} + (LO_W + 1)'(24'h80_0000);
    c_mag_nxt = {1'b0, c_hi, 8'd0} + MAG_W'(c_lo_rnd[LO_W:24]);
  end

  always_comb begin
    if (c_neg_r) begin
      d_magc = (c_mag_r >= MAG_W'(ACC_MIN)) ? ACC_MIN : c_mag_r[ACC_W-1:0];
      d_sum_nxt = {coef_r[2][ACC_W-1], coef_r[2]} - $signed({1'b0, d_magc});
    end else begin
      d_magc = (c_mag_r > MAG_W'(ACC_MAX)) ? ACC_MAX : c_mag_r[ACC_W-1:0];
      d_sum_nxt = {coef_r[2][ACC_W-1], coef_r[2]} + $signed({1'b0, d_magc});
    end
  end

  always_comb begin
    if (d_sum_r[ACC_W] != d_sum_r[ACC_W-1]) begin
      e_acc_nxt = d_sum_r[ACC_W] ? ACC_MIN : ACC_MAX;
    end else begin
      e_acc_nxt = d_sum_r[ACC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[HORNER_LAT-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    dif_r[0]  <= in_dif;
    sb_r[0]   <= in_sb;
    for (int i = 1; i < HORNER_LAT; i++) begin
      dif_r[i] <= dif_r[i-1];
      sb_r[i]  <= sb_r[i-1];
    end
    coef_r[0] <= in_coef;
    coef_r[1] <= coef_r[0];
    coef_r[2] <= coef_r[1];
    a_mc_r    <= a_mc_nxt;
    a_md_r    <= a_md_nxt;
    a_neg_r   <= in_acc[ACC_W-1] ^ in_dif[DIF_W-1];
    b_lo_r    <= b_lo_nxt;
    b_mc_hi_r <= a_mc_r[ACC_W-1:32];
    b_md_r    <= a_md_r;
    b_neg_r   <= a_neg_r;
    c_mag_r   <= c_mag_nxt;
    c_neg_r   <= b_neg_r;
    d_sum_r   <= d_sum_nxt;
    e_acc_r   <= e_acc_nxt;
  end

  assign out_vld = vld_r[HORNER_LAT-1];
  assign out_acc = e_acc_r;
  assign out_dif = dif_r[HORNER_LAT-1];
  assign out_sb  = sb_r[HORNER_LAT-1];

endmodule
`default_nettype wire

// ----- rtl/spline_table_function_evaluator.sv -----
// Top level: index pipeline, coefficient stores and three Horner steps.
// A result passes through stages s1 to s5, the three Horner steps and the output register.
// Throughput: one item per cycle; busy is never raised, writes and evaluations interleave.
// Writes give no result; the coefficient stores take them from the s2 registers, after s1 and s2.
// Reset (synchronous, rst_n low) clears the pipeline valids and both config registers.
// The coefficient stores are not cleared; entries read before being written are undefined.
`default_nettype none
module spline_table_function_evaluator
  import stfe_pkg::*;
#(
  parameter int TABLE_DEPTH = 1024,
  parameter int NUM_KINDS   = 5
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  stfe_in_t             in_item,
  output logic                 out_valid,
  output stfe_out_t            out_item,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  localparam int IW       = $clog2(TABLE_DEPTH);
  localparam int STORE    = NUM_KINDS * TABLE_DEPTH;
  localparam int AW       = $clog2(STORE);
  localparam int BW       = IW + 1 + DIST_W;
  localparam int PIPE_LAT = 6 + 3 * HORNER_LAT;

  logic [CFG_W-1:0] step_r, inv_step_r;

  logic accept;

  // s1: index product
  logic             s1_vld_r;
  stfe_in_t         s1_item_r;
  logic [63:0]      s1_prod_r, s1_prod_nxt;
  // s2: clamp
  logic [23:0]      s2_idx_raw;
  logic             s2_kind_ok_nxt, s2_clamp;
  logic [IW-1:0]    s2_idx_nxt;
  logic [1:0]       s2_status_nxt;
  logic             s2_vld_r, s2_kind_ok_r;
  stfe_in_t         s2_item_r;
  logic [IW-1:0]    s2_idx_r;
  logic [1:0]       s2_status_r;
  // s3: store access and base
  logic [IW-1:0]    s3_row;
  logic [AW-1:0]    s3_kind_a, s3_addr;
  logic             s3_wr_ok, s3_entry_ok;
  logic             we_a, we_b, we_c, we_d;
  logic [IW:0]      s3_idx_p1;
  logic [BW-1:0]    s3_base_nxt;
  logic             s3_vld_r;
  logic [DIST_W-1:0] s3_dist_r;
  logic [1:0]       s3_status_r;
  logic [BW-1:0]    s3_base_r;
  logic signed [ACC_W-1:0] rd_a_r, rd_b_r, rd_c_r, rd_d_r;
  logic signed [ACC_W-1:0] mem_a [STORE];
  logic signed [ACC_W-1:0] mem_b [STORE];
  logic signed [ACC_W-1:0] mem_c [STORE];
  logic signed [ACC_W-1:0] mem_d [STORE];
  // s4: raw difference
  logic             s4_vld_r;
  logic signed [BW:0] s4_dif_raw_r, s4_dif_raw_nxt;
  logic [1:0]       s4_status_r;
  logic signed [ACC_W-1:0] s4_a_r, s4_b_r, s4_c_r, s4_d_r;
  // s5: saturated difference
  logic signed [DIF_W-1:0] s5_dif_nxt;
  logic             s5_vld_r;
  logic signed [DIF_W-1:0] s5_dif_r;
  logic [1:0]       s5_status_r;
  logic signed [ACC_W-1:0] s5_a_r, s5_b_r, s5_c_r, s5_d_r;
  // Horner chain
  localparam int SB1_W = 2 + 2 * ACC_W;
  localparam int SB2_W = 2 + ACC_W;
  logic                    h1_vld, h2_vld, h3_vld;
  logic signed [ACC_W-1:0] h1_acc, h2_acc, h3_acc;
  logic signed [DIF_W-1:0] h1_dif, h2_dif;
  logic [SB1_W-1:0]        h1_sb;
  logic [SB2_W-1:0]        h2_sb;
  logic [1:0]              h3_sb;
  // output
  logic      out_valid_r;
  stfe_out_t out_item_r, out_item_nxt;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r     <= '0;
      inv_step_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_STEP_WIDTH:   step_r     <= cfg_wdata;
        CFG_INVERSE_STEP: inv_step_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign s1_prod_nxt = 64'(in_item.distance) * 64'(inv_step_r);

  always_comb begin
    s2_idx_raw     = s1_prod_r[63:40];
    s2_kind_ok_nxt = 32'(s1_item_r.kind) < NUM_KINDS;
    s2_clamp       = 32'(s2_idx_raw) > TABLE_DEPTH - 1;
    if (s2_clamp) begin
      s2_idx_nxt = IW'(TABLE_DEPTH - 1);
    end else if (s2_idx_raw == 24'd0) begin
      s2_idx_nxt = IW'(1);
    end else begin
      s2_idx_nxt = IW'(s2_idx_raw);
    end
    if (!s2_kind_ok_nxt) begin
      s2_status_nxt = ST_KIND;
    end else if (s2_clamp) begin
      s2_status_nxt = ST_CLAMP;
    end else begin
      s2_status_nxt = ST_OK;
    end
  end

  always_comb begin
    s3_row      = (s2_item_r.op == OP_WRITE) ? IW'(s2_item_r.entry) : s2_idx_r;
    s3_kind_a   = s2_kind_ok_r ? AW'(s2_item_r.kind) : '0;
    s3_addr     = s3_kind_a * AW'(TABLE_DEPTH) + AW'(s3_row);
    s3_entry_ok = 32'(s2_item_r.entry) < TABLE_DEPTH;
    s3_wr_ok    = s2_vld_r && (s2_item_r.op == OP_WRITE) && s2_kind_ok_r && s3_entry_ok;
    we_a        = s3_wr_ok && (s2_item_r.coef_select == SEL_A);
    we_b        = s3_wr_ok && (s2_item_r.coef_select == SEL_B);
    we_c        = s3_wr_ok && (s2_item_r.coef_select == SEL_C);
    we_d        = s3_wr_ok && (s2_item_r.coef_select == SEL_D);
    s3_idx_p1   = {1'b0, s2_idx_r} + (IW + 1)'(1);
    s3_base_nxt = BW'(s3_idx_p1) * BW'(step_r);
  end

  always_ff @(posedge clk) begin
    if (we_a) mem_a[s3_addr] <= s2_item_r.coef_value;
    if (we_b) mem_b[s3_addr] <= s2_item_r.coef_value;
    if (we_c) mem_c[s3_addr] <= s2_item_r.coef_value;
    if (we_d) mem_d[s3_addr] <= s2_item_r.coef_value;
    rd_a_r <= mem_a[s3_addr];
    rd_b_r <= mem_b[s3_addr];
    rd_c_r <= mem_c[s3_addr];
    rd_d_r <= mem_d[s3_addr];
  end

  assign s4_dif_raw_nxt = $signed({1'b0, BW'(s3_dist_r)}) - $signed({1'b0, s3_base_r});

  always_comb begin
    if ((&s4_dif_raw_r[BW:DIF_W-1]) || !(|s4_dif_raw_r[BW:DIF_W-1])) begin
      s5_dif_nxt = s4_dif_raw_r[DIF_W-1:0];
    end else if (s4_dif_raw_r[BW]) begin
      s5_dif_nxt = {1'b1, {(DIF_W-1){1'b0}}};
    end else begin
      s5_dif_nxt = {1'b0, {(DIF_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
      s5_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= accept;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r && (s2_item_r.op == OP_EVAL);
      s4_vld_r <= s3_vld_r;
      s5_vld_r <= s4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_item_r    <= in_item;
    s1_prod_r    <= s1_prod_nxt;
    s2_item_r    <= s1_item_r;
    s2_idx_r     <= s2_idx_nxt;
    s2_status_r  <= s2_status_nxt;
    s2_kind_ok_r <= s2_kind_ok_nxt;
    s3_dist_r    <= s2_item_r.distance;
    s3_status_r  <= s2_status_r;
    s3_base_r    <= s3_base_nxt;
    s4_dif_raw_r <= s4_dif_raw_nxt;
    s4_status_r  <= s3_status_r;
    s4_a_r       <= rd_a_r;
    s4_b_r       <= rd_b_r;
    s4_c_r       <= rd_c_r;
    s4_d_r       <= rd_d_r;
    s5_dif_r     <= s5_dif_nxt;
    s5_status_r  <= s4_status_r;
    s5_a_r       <= s4_a_r;
    s5_b_r       <= s4_b_r;
    s5_c_r       <= s4_c_r;
    s5_d_r       <= s4_d_r;
  end

  stfe_horner #(.SB_W(SB1_W)) u_step_c (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (s5_vld_r),
    .in_acc  (s5_d_r),
    .in_dif  (s5_dif_r),
    .in_coef (s5_c_r),
    .in_sb   ({s5_status_r, s5_b_r, s5_a_r}),
    .out_vld (h1_vld),
    .out_acc (h1_acc),
    .out_dif (h1_dif),
    .out_sb  (h1_sb)
  );

  stfe_horner #(.SB_W(SB2_W)) u_step_b (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (h1_vld),
    .in_acc  (h1_acc),
    .in_dif  (h1_dif),
    .in_coef ($signed(h1_sb[2*ACC_W-1:ACC_W])),
    .in_sb   ({h1_sb[SB1_W-1:2*ACC_W], h1_sb[ACC_W-1:0]}),
    .out_vld (h2_vld),
    .out_acc (h2_acc),
    .out_dif (h2_dif),
    .out_sb  (h2_sb)
  );

  stfe_horner #(.SB_W(2)) u_step_a (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (h2_vld),
    .in_acc  (h2_acc),
    .in_dif  (h2_dif),
    .in_coef ($signed(h2_sb[ACC_W-1:0])),
    .in_sb   (h2_sb[SB2_W-1:ACC_W]),
    .out_vld (h3_vld),
    .out_acc (h3_acc),
    .out_dif (),
    .out_sb  (h3_sb)
  );

  always_comb begin
    out_item_nxt.status = h3_sb;
    out_item_nxt.value  = (h3_sb == ST_KIND) ? '0 : h3_acc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= h3_vld;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_result_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy && in_item.op == OP_EVAL, PIPE_LAT))
    else $error("result without a matching evaluate item");

  a_unknown_kind_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status == ST_KIND |-> out_item.value == '0)
    else $error("unknown kind gave a non-zero value");

  a_one_store_write: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({we_a, we_b, we_c, we_d}))
    else $error("more than one coefficient store written");

  a_clamp_index: assert property (@(posedge clk) disable iff (!rst_n)
    s2_vld_r && s2_status_r == ST_CLAMP |-> s2_idx_r == IW'(TABLE_DEPTH - 1))
    else $error("clamped item not on last segment");

endmodule
`default_nettype wire

// ----- bench/tb.sv -----
// Self-checking bench for the spline table function evaluator: scored against an in-bench predictor.
`default_nettype none
module tb;
  import stfe_pkg::*;

  localparam int          N_TABLES       = 5;
  localparam int          SEGMENTS       = 1024;
  localparam int          RESULT_LATENCY = 21;
  localparam int          DRAIN_TAIL     = RESULT_LATENCY + 10;
  localparam int          DRAIN_LIMIT    = 400;
  localparam longint      ACC_HI         = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint      ACC_LO         = -ACC_HI - 1;
  localparam longint      DIF_HI         = 64'sh0000_0000_7FFF_FFFF;
  localparam longint      DIF_LO         = -DIF_HI - 1;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 start     = 1'b0;
  logic                 busy;
  stfe_in_t             in_item   = '0;
  logic                 out_valid;
  stfe_out_t            out_item;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  spline_table_function_evaluator DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [31:0] step_cfg = '0;
  logic [31:0] inv_cfg  = '0;
  longint      coef_store   [4][N_TABLES*SEGMENTS];
  bit   [3:0]  coef_written [N_TABLES*SEGMENTS];

  stfe_out_t pending_results[$];
  int        failures  = 0;
  bit        idling_on = 1'b1;

  task automatic report(input string msg);
    if (failures < 10) $display("%s", msg);
    failures++;
  endtask

  function automatic longint clip_acc(input longint v);
    if (v > ACC_HI) return ACC_HI;
    if (v < ACC_LO) return ACC_LO;
    return v;
  endfunction

  // coef * dif >> 24, rounded half away from zero, saturated to 48 bits
  function automatic longint scaled_product(input longint c, input longint d);
    bit          neg;
    logic [95:0] mc;
    logic [95:0] md;
    logic [95:0] mag;
    neg = (c < 0) != (d < 0);
    mc  = (c < 0) ? 96'(-c) : 96'(c);
    md  = (d < 0) ? 96'(-d) : 96'(d);
    mag = (mc * md + (96'd1 << 23)) >> 24;
    if (neg) begin
      if (mag >= 96'h8000_0000_0000) return ACC_LO;
      return -longint'(mag[63:0]);
    end
    if (mag > 96'h7FFF_FFFF_FFFF) return ACC_HI;
    return longint'(mag[63:0]);
  endfunction

  // segment index before clamping, index 0 raised to 1
  function automatic longint raw_segment(input logic [31:0] distance);
    logic [63:0] p;
    p = ({32'd0, distance} * {32'd0, inv_cfg}) >> 40;
    if (p == 64'd0) p = 64'd1;
    return longint'(p);
  endfunction

  function automatic stfe_out_t evaluate_spline(input stfe_in_t it);
    stfe_out_t   res;
    longint      seg;
    longint      dif;
    longint      acc;
    logic [63:0] base;
    int unsigned addr;
    res.value  = '0;
    res.status = ST_OK;
    if (it.kind >= N_TABLES) begin
      res.status = ST_KIND;
      return res;
    end
    seg = raw_segment(it.distance);
    if (seg > SEGMENTS - 1) begin
      seg        = longint'(SEGMENTS - 1);
      res.status = ST_CLAMP;
    end
    base = 64'(seg + 1) * {32'd0, step_cfg};
    dif  = longint'({32'd0, it.distance}) - longint'(base);
    if (dif > DIF_HI) dif = DIF_HI;
    if (dif < DIF_LO) dif = DIF_LO;
    addr = it.kind * SEGMENTS + int'(seg);
    acc  = coef_store[SEL_D][addr];
    acc  = clip_acc(scaled_product(acc, dif) + coef_store[SEL_C][addr]);
    acc  = clip_acc(scaled_product(acc, dif) + coef_store[SEL_B][addr]);
    acc  = clip_acc(scaled_product(acc, dif) + coef_store[SEL_A][addr]);
    res.value = acc[47:0];
    return res;
  endfunction

  function automatic void load_coefficient(input stfe_in_t it);
    int unsigned addr;
    if (it.kind < N_TABLES) begin
      addr = it.kind * SEGMENTS + it.entry;
      coef_store[it.coef_select][addr]   = longint'($signed(it.coef_value));
      coef_written[addr][it.coef_select] = 1'b1;
    end
  endfunction

  function automatic logic [47:0] rand_coef();
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0:          return ACC_MAX;
      1:          return ACC_MIN;
      2, 3, 4, 5: return r[47:0];
      default:    return {{12{r[35]}}, r[35:0]};
    endcase
  endfunction

  function automatic stfe_in_t make_write(input logic [2:0] kind, input logic [9:0] entry,
                                          input logic [1:0] sel, input logic [47:0] value);
    stfe_in_t it;
    it.op          = OP_WRITE;
    it.kind        = kind;
    it.distance    = $urandom;
    it.entry       = entry;
    it.coef_select = sel;
    it.coef_value  = value;
    return it;
  endfunction

  function automatic stfe_in_t make_eval(input logic [2:0] kind, input logic [31:0] distance);
    stfe_in_t it;
    it.op          = OP_EVAL;
    it.kind        = kind;
    it.distance    = distance;
    it.entry       = 10'($urandom);
    it.coef_select = 2'($urandom);
    it.coef_value  = rand_coef();
    return it;
  endfunction

  function automatic logic [31:0] pick_distance();
    logic [63:0] upper;
    upper = 64'(SEGMENTS + 76) * {32'd0, step_cfg};
    if ($urandom_range(0, 3) == 0 || upper == 0 || upper > 64'hFFFF_FFFF) return $urandom;
    return $urandom_range(0, upper[31:0]);
  endfunction

  task automatic send_item(input stfe_in_t it);
    in_item <= it;
    start   <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    if (it.op == OP_WRITE) load_coefficient(it);
    else pending_results.push_back(evaluate_spline(it));
  endtask

  task automatic rest(input int n);
    start   <= 1'b0;
    in_item <= stfe_in_t'({$urandom, $urandom, $urandom});
    repeat (n) @(posedge clk);
  endtask

  task automatic pace();
    if (idling_on && $urandom_range(0, 7) == 0) rest($urandom_range(1, 12));
  endtask

  task automatic drain();
    int waited;
    waited = 0;
    start <= 1'b0;
    while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pending_results.size() != 0) begin
      report($sformatf("%0d expected results never arrived", pending_results.size()));
      pending_results.delete();
    end
    repeat (DRAIN_TAIL) @(posedge clk);
  endtask

  task automatic program_config(input logic [31:0] step, input logic [31:0] inv);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_STEP_WIDTH;
    cfg_wdata <= step;
    @(posedge clk);
    step_cfg = step;
    cfg_index <= CFG_INVERSE_STEP;
    cfg_wdata <= inv;
    @(posedge clk);
    inv_cfg = inv;
    cfg_we <= 1'b0;
  endtask

  // write whichever coefficients of the segment a distance lands on are still unset
  task automatic prime_segment(input logic [2:0] kind, input logic [31:0] distance);
    longint      seg;
    int unsigned addr;
    int          s;
    seg = raw_segment(distance);
    if (seg > SEGMENTS - 1) seg = longint'(SEGMENTS - 1);
    addr = kind * SEGMENTS + int'(seg);
    for (s = 0; s < 4; s++) begin
      if (!coef_written[addr][s]) begin
        send_item(make_write(kind, seg[9:0], s[1:0], rand_coef()));
        pace();
      end
    end
  endtask

  task automatic run_random_mix(input int n);
    int          i;
    int          pick;
    logic [2:0]  kind;
    logic [31:0] dval;
    for (i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        kind = 3'($urandom_range(0, N_TABLES - 1));
        dval = pick_distance();
        prime_segment(kind, dval);
        send_item(make_eval(kind, dval));
      end else if (pick < 80) begin
        send_item(make_write(3'($urandom_range(0, N_TABLES - 1)), 10'($urandom),
                             2'($urandom), rand_coef()));
      end else if (pick < 90) begin
        send_item(make_eval(3'($urandom_range(N_TABLES, 7)), $urandom));
      end else begin
        send_item(make_write(3'($urandom_range(N_TABLES, 7)), 10'($urandom),
                             2'($urandom), rand_coef()));
      end
      pace();
    end
  endtask

  // config still at reset: index always 1, dif is the distance itself saturated to signed 32 bits
  task automatic test_reset_state();
    send_item(make_write(3'd0, 10'd1, SEL_A, ACC_MAX));
    send_item(make_write(3'd0, 10'd1, SEL_B, ACC_MIN));
    send_item(make_write(3'd0, 10'd1, SEL_C, 48'd1));
    send_item(make_write(3'd0, 10'd1, SEL_D, 48'hFFFF_FFFF_FFFF));
    send_item(make_eval(3'd0, 32'h0000_0000));
    send_item(make_eval(3'd0, 32'hFFFF_FFFF));
    send_item(make_eval(3'd0, 32'h0100_0000));
    send_item(make_eval(3'd5, $urandom));
    send_item(make_eval(3'd7, 32'hFFFF_FFFF));
    send_item(make_write(3'd7, 10'd1, SEL_A, ACC_MIN));
    send_item(make_write(3'd0, 10'd0, SEL_A, rand_coef()));
    send_item(make_write(3'd0, 10'd1023, SEL_D, rand_coef()));
    send_item(make_eval(3'd0, 32'h0000_0000));
    drain();
  endtask

  // index = distance >> 16; top segment, first segment and clamping
  task automatic test_segment_clamp();
    program_config(32'h0001_0000, 32'h0100_0000);
    prime_segment(3'd4, 32'h0400_0000);
    send_item(make_eval(3'd4, 32'h03FF_8000));
    send_item(make_eval(3'd4, 32'h0400_0000));
    send_item(make_eval(3'd4, 32'hFFFF_FFFF));
    prime_segment(3'd4, 32'h0000_8000);
    send_item(make_eval(3'd4, 32'h0000_8000));
    send_item(make_eval(3'd4, 32'h0001_FFFF));
    drain();
  endtask

  task automatic test_config_extremes();
    int p;
    for (p = 0; p < 4; p++) begin
      case (p)
        0:       program_config(32'h0000_0000, 32'hFFFF_FFFF);
        1:       program_config(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        2:       program_config(32'hFFFF_FFFF, 32'h0000_0000);
        default: program_config(32'h0000_0000, 32'h0000_0000);
      endcase
      run_random_mix(40);
      drain();
    end
  endtask

  task automatic program_spacing();
    logic [31:0] s;
    logic [63:0] q;
    s = $urandom_range(32'h0000_1000, 32'h003F_FFFF);
    q = (64'd1 << 40) / s;
    program_config(s, q[31:0]);
  endtask

  task automatic test_realistic_tables();
    int p;
    for (p = 0; p < 4; p++) begin
      program_spacing();
      run_random_mix(40);
      drain();
    end
  endtask

  task automatic test_back_to_back();
    idling_on = 1'b0;
    program_spacing();
    run_random_mix(50);
    drain();
  endtask

  always @(posedge clk) begin : check_results
    stfe_out_t want;
    if (rst_n === 1'b1 && out_valid !== 1'b0) begin
      if (pending_results.size() == 0) begin
        report($sformatf("unexpected result: value %h status %0d",
                         out_item.value, out_item.status));
      end else begin
        want = pending_results.pop_front();
        if (out_item.value !== want.value || out_item.status !== want.status)
          report($sformatf("mismatch: expected value %h status %0d, got value %h status %0d",
                           want.value, want.status, out_item.value, out_item.status));
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_segment_clamp();
    test_config_extremes();
    test_realistic_tables();
    test_back_to_back();
    if (failures == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

endmodule
`default_nettype wire

// ----- spline_table_function_evaluator.f -----
rtl/stfe_pkg.sv
rtl/stfe_horner.sv
rtl/spline_table_function_evaluator.sv
bench/tb.sv
